>>> hw/rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES   = 2'd1;

  localparam int CHUNK = 8;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_MOD,
    K_BAD
  } kind_e;

  typedef struct packed {
    logic clr;
    logic capture;
    logic scan_rd;
    logic scan_step;
    logic mark_rd;
    logic mark_wr;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_e kind;
    logic  scan_fin;
    logic  scan_found;
    logic  word_end;
    logic  mark_last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/bpa_intf.sv
`default_nettype none
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] num_pages;
  logic [31:0] address;
  modport source (output valid, command, num_pages, address, input ready);
  modport sink (input valid, command, num_pages, address, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;
  modport source (output valid, status, result_address, input ready);
  modport sink (input valid, status, result_address, output ready);
endinterface

interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  wire                  rsp_ready_i,
  input  bpa_pkg::dp_stat_t    stat_i,
  output bpa_pkg::ctrl_cmd_t   cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   free_slot;

  assign free_slot   = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (stat_i.kind)
            K_ALLOC: state_d = S_SCAN_RD;
            K_MOD:   state_d = S_MARK_RD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (stat_i.scan_fin && stat_i.scan_found) state_d = S_MARK_RD;
        else if (stat_i.scan_fin) state_d = S_DONE;
        else if (stat_i.word_end) state_d = S_SCAN_RD;
        else state_d = S_SCAN;
      end
      S_MARK_RD: begin
        cmd_o.mark_rd = 1'b1;
        state_d       = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = stat_i.mark_last ? S_DONE : S_MARK_RD;
      end
      S_DONE: begin
        if (free_slot) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q && !req_ready_o)
    else $error("activity during clearing pass");
  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> free_slot)
    else $error("result loaded over a pending result");
  a_found_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_step && stat_i.scan_fin && stat_i.scan_found) |=> (state_q == S_MARK_RD))
    else $error("found run not marked");
  a_mark_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mark_wr && !stat_i.mark_last) |=> (state_q == S_MARK_RD))
    else $error("marking stopped early");

endmodule
`default_nettype wire

>>> hw/rtl/bpa_datapath.sv
`default_nettype none
module bpa_datapath #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_BYTES = 4096
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bpa_pkg::ctrl_cmd_t   cmd_i,
  output bpa_pkg::dp_stat_t    stat_o,
  input  wire [1:0]            command_i,
  input  wire [10:0]           num_pages_i,
  input  wire [31:0]           address_i,
  input  wire                  cfg_we_i,
  input  wire [1:0]            cfg_index_i,
  input  wire [31:0]           cfg_data_i,
  output logic [1:0]           status_o,
  output logic [31:0]          result_address_o
);
  import bpa_pkg::*;

  localparam int WORDS      = (MAX_PAGES + 31) / 32;
  localparam int WIDX       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW         = $clog2(MAX_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PIW        = 32 - PAGE_SHIFT;

  logic [31:0]     mem [WORDS];
  logic [31:0]     rd_q;
  logic [WIDX-1:0] mem_addr;
  logic [31:0]     wr_data;

  logic [31:0]     base_q;
  logic [10:0]     pool_q;
  logic [WIDX-1:0] clr_q;

  logic            is_alloc_q;
  logic            set_q;
  logic [10:0]     cnt_q;
  logic [PW-1:0]   lo_q, hi_q, pos_q;
  logic [10:0]     run_q;
  logic [WIDX-1:0] widx_q;
  logic [1:0]      res_st_q;

  logic [31:0]     lim32;
  logic [PW-1:0]   limit;
  logic            below;
  logic [31:0]     off;
  logic [PIW-1:0]  pidx;
  logic [32:0]     free_end;
  logic            free_ok, rsv_ok;
  kind_e           kind;
  logic [PW-1:0]   cap_lo, cap_hi;

  logic [10:0]     ch_run;
  logic            ch_found;
  logic [PW-1:0]   ch_start;
  logic [31:0]     pos_next;
  logic [31:0]     wbase, mark_next;
  logic [31:0]     mask;
  logic [63:0]     start_sh;

  assign lim32 = (32'(pool_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(pool_q);
  assign limit = PW'(lim32);
  assign below = address_i < base_q;
  assign off   = address_i - base_q;
  assign pidx  = off[31:PAGE_SHIFT];
  assign free_end = 33'(pidx) + 33'(num_pages_i);
  assign free_ok  = (num_pages_i != 11'd0) && !below && (free_end <= 33'(limit));
  assign rsv_ok   = !below && (32'(pidx) < 32'(limit));
  assign cap_lo   = PW'(pidx);
  assign cap_hi   = (command_i == CMD_FREE) ? PW'(free_end) : PW'(33'(pidx) + 33'd1);

  always_comb begin
    unique case (command_i)
      CMD_ALLOC:   kind = (num_pages_i != 11'd0) ? K_ALLOC : K_BAD;
      CMD_FREE:    kind = free_ok ? K_MOD : K_BAD;
      CMD_RESERVE: kind = rsv_ok ? K_MOD : K_BAD;
      default:     kind = K_BAD;
    endcase
  end

  // first-fit over one chunk of the registered word
  always_comb begin
    logic [31:0] pg;
    ch_run   = run_q;
    ch_found = 1'b0;
    ch_start = '0;
    for (int j = 0; j < CHUNK; j++) begin
      pg = 32'(pos_q) + 32'(j);
      if (!ch_found && (pg < 32'(limit))) begin
        if (rd_q[{pos_q[4:3], 3'(j)}]) begin
          ch_run = '0;
        end else begin
          ch_run = ch_run + 11'd1;
          if (ch_run == cnt_q) begin
            ch_found = 1'b1;
            ch_start = PW'(pg + 32'd1 - 32'(cnt_q));
          end
        end
      end
    end
  end

  assign pos_next  = 32'(pos_q) + 32'(CHUNK);
  assign wbase     = 32'(widx_q) << 5;
  assign mark_next = wbase + 32'd32;

  always_comb begin
    logic [31:0] pg;
    for (int b = 0; b < 32; b++) begin
      pg      = wbase | 32'(b);
      mask[b] = (pg >= 32'(lo_q)) && (pg < 32'(hi_q));
    end
  end

  assign wr_data = cmd_i.clr ? 32'd0 : (set_q ? (rd_q | mask) : (rd_q & ~mask));

  always_comb begin
    priority if (cmd_i.clr) mem_addr = clr_q;
    else if (cmd_i.scan_rd) mem_addr = WIDX'(pos_q >> 5);
    else mem_addr = widx_q;
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (32'(clr_q) == 32'(WORDS - 1));
    stat_o.kind       = kind;
    stat_o.scan_fin   = ch_found || (pos_next >= 32'(limit));
    stat_o.scan_found = ch_found;
    stat_o.word_end   = (pos_q[4:3] == 2'b11);
    stat_o.mark_last  = mark_next >= 32'(hi_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr || cmd_i.mark_wr) mem[mem_addr] <= wr_data;
    if (cmd_i.scan_rd || cmd_i.mark_rd) rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pool_q <= 11'd1024;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_BASE_ADDRESS)) base_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_POOL_PAGES)) pool_q <= cfg_data_i[10:0];
      if (cmd_i.clr) clr_q <= clr_q + WIDX'(1);
    end
  end

  assign start_sh = 64'(lo_q) << PAGE_SHIFT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_alloc_q <= (kind == K_ALLOC);
      set_q      <= (command_i != CMD_FREE);
      cnt_q      <= num_pages_i;
      lo_q       <= cap_lo;
      hi_q       <= cap_hi;
      widx_q     <= WIDX'(cap_lo >> 5);
      pos_q      <= '0;
      run_q      <= '0;
      res_st_q   <= (kind == K_BAD) ? ST_BAD : ST_OK;
    end
    if (cmd_i.scan_step) begin
      run_q <= ch_run;
      pos_q <= PW'(pos_next);
      if (ch_found) begin
        lo_q   <= ch_start;
        hi_q   <= PW'(32'(ch_start) + 32'(cnt_q));
        widx_q <= WIDX'(ch_start >> 5);
      end else if (stat_o.scan_fin) begin
        res_st_q <= ST_NOSPACE;
      end
    end
    if (cmd_i.mark_wr) widx_q <= widx_q + WIDX'(1);
    if (cmd_i.load) begin
      status_o         <= res_st_q;
      result_address_o <= (is_alloc_q && (res_st_q == ST_OK)) ?
                          (base_q + start_sh[31:0]) : 32'd0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bitmap_page_allocator.sv
`default_nettype none
// allocate: capture, a read and chunk checks per word scanned, a read and a write
// per word marked; free and reserve: capture, a read and a write per word touched;
// bad requests go straight to the result; the scan checks 8 pages a cycle; the
// result loads once the output slot is free; one request at a time, the next
// taken the cycle after it is loaded; after reset a clearing pass zeroes every
// bitmap word before any request; PAGE_BYTES must be a power of two
module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_BYTES = 4096
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bpa_req_if.sink    req_if,
  bpa_rsp_if.source  rsp_if,
  bpa_cfg_if.sink    cfg_if
);
  import bpa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_if.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .rsp_valid_o (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .command_i        (req_if.command),
    .num_pages_i      (req_if.num_pages),
    .address_i        (req_if.address),
    .cfg_we_i         (cfg_if.valid),
    .cfg_index_i      (cfg_if.index),
    .cfg_data_i       (cfg_if.data),
    .status_o         (rsp_if.status),
    .result_address_o (rsp_if.result_address)
  );

endmodule
`default_nettype wire
